@@ rtl/memory_map_bank_swap_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the memory map decoder
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MEMORY_MAP_BANK_SWAP_DECODER_ASSERT_SVH
`define MEMORY_MAP_BANK_SWAP_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define MMBSD_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
`define MMBSD_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMBSD_ASSERT_IMP(label, ck, rn, ante, cons, msg)
`define MMBSD_ASSERT_NXT(label, ck, rn, ante, cons, msg)
`endif

`endif

@@ rtl/mmbsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Memory map decoder package
// Payload types, operation and target codes, address map constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmbsd_pkg;

  localparam int MAIN_DEPTH  = 49152;
  localparam int MAIN_AW     = $clog2(MAIN_DEPTH);
  localparam int VIDEO_DEPTH = 1024;
  localparam int VIDEO_AW    = $clog2(VIDEO_DEPTH);

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_TEMPO  = 3'd2;
  localparam logic [2:0] OP_BLINK  = 3'd3;
  localparam logic [2:0] OP_LINE   = 3'd4;
  localparam logic [2:0] OP_HBEND  = 3'd5;

  localparam logic [3:0] TGT_NONE    = 4'd0;
  localparam logic [3:0] TGT_LOCAL   = 4'd1;
  localparam logic [3:0] TGT_PIO     = 4'd2;
  localparam logic [3:0] TGT_TIMER   = 4'd3;
  localparam logic [3:0] TGT_GATE0   = 4'd4;
  localparam logic [3:0] TGT_IPL     = 4'd5;
  localparam logic [3:0] TGT_EXT     = 4'd6;
  localparam logic [3:0] TGT_PORTC   = 4'd7;
  localparam logic [3:0] TGT_REVERSE = 4'd8;

  localparam logic [15:0] ADDR_PAGE0_END = 16'h1000;
  localparam logic [15:0] ADDR_RAM_BASE  = 16'h1000;
  localparam logic [15:0] ADDR_SWAP_BASE = 16'hB000;
  localparam logic [15:0] ADDR_HIPAGE    = 16'hC000;
  localparam logic [15:0] ADDR_VRAM      = 16'hD000;
  localparam logic [15:0] ADDR_IO_LO     = 16'hE000;
  localparam logic [15:0] ADDR_PIO_HI    = 16'hE003;
  localparam logic [15:0] ADDR_TIMER_HI  = 16'hE007;
  localparam logic [15:0] ADDR_STATUS    = 16'hE008;
  localparam logic [15:0] ADDR_SWAP_ON   = 16'hE00C;
  localparam logic [15:0] ADDR_SWAP_OFF  = 16'hE010;
  localparam logic [15:0] ADDR_REV_OFF   = 16'hE014;
  localparam logic [15:0] ADDR_REV_ON    = 16'hE015;
  localparam logic [15:0] ADDR_IO_HI     = 16'hE7FF;
  localparam logic [15:0] ADDR_EXT_BASE  = 16'hE800;

  localparam logic [7:0] STATUS_BASE  = 8'hFE;
  localparam logic [7:0] STATUS_LATER = 8'h7E;
  localparam logic [7:0] BYTE_FF      = 8'hFF;

  localparam logic [8:0]  LINE_VBLANK_ON  = 9'd0;
  localparam logic [8:0]  LINE_VBLANK_OFF = 9'd200;
  localparam logic [11:0] PORTC_BLINK     = 12'd6;
  localparam logic [11:0] PORTC_VBLANK    = 12'd7;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_byte;
    logic [8:0]  line_number;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [11:0] target_offset;
    logic [7:0]  result_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_MAIN,
    RD_VIDEO
  } rd_sel_t;

  typedef struct packed {
    logic swapped;
    logic tempo;
    logic blink;
    logic hblank;
  } flags_t;

  typedef struct packed {
    out_item_t             res;
    rd_sel_t               rd_sel;
    logic                  main_we;
    logic [MAIN_AW-1:0]    main_addr;
    logic                  video_we;
    logic [VIDEO_AW-1:0]   video_addr;
    logic                  swap_set;
    logic                  swap_clr;
    logic                  tempo_tgl;
    logic                  blink_tgl;
    logic                  hblank_set;
    logic                  hblank_clr;
  } dec_t;

endpackage

`default_nettype wire

@@ rtl/mmbsd_ram.sv @@
// ----------------------------------------------------------------------------
// Single-port synchronous RAM
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmbsd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mmbsd_decode.sv @@
// ----------------------------------------------------------------------------
// Address and event decoder
// Maps one bus access or timing event to a result, RAM accesses and flag updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmbsd_decode
  import mmbsd_pkg::*;
(
  input  wire in_item_t item,
  input  wire logic     variant,
  input  wire flags_t   flags,
  output dec_t          dec
);

  logic [15:0] a;
  logic [15:0] ext_off;
  logic        in_io;
  logic        in_hi_rom;

  assign a         = item.address;
  assign ext_off   = a - ADDR_EXT_BASE;
  assign in_io     = (a >= ADDR_IO_LO) && (a <= ADDR_IO_HI);
  assign in_hi_rom = (a >= ADDR_HIPAGE) && (a < ADDR_VRAM) && flags.swapped;

  always_comb begin
    dec            = '0;
    dec.rd_sel     = RD_NONE;
    dec.main_addr  = MAIN_AW'(a - ADDR_RAM_BASE);
    dec.video_addr = a[VIDEO_AW-1:0];
    case (item.operation)
      OP_READ: begin
        if (in_io) begin
          if (a <= ADDR_PIO_HI) begin
            dec.res.target        = TGT_PIO;
            dec.res.target_offset = {10'd0, a[1:0]};
          end else if (a <= ADDR_TIMER_HI) begin
            dec.res.target        = TGT_TIMER;
            dec.res.target_offset = {10'd0, a[1:0]};
          end else if (a == ADDR_STATUS) begin
            dec.res.target = TGT_LOCAL;
            if (variant) begin
              dec.res.result_byte = {flags.hblank, 7'd0} | STATUS_LATER | {7'd0, flags.tempo};
            end else begin
              dec.res.result_byte = STATUS_BASE | {7'd0, flags.tempo};
            end
          end else begin
            dec.res.target      = TGT_LOCAL;
            dec.res.result_byte = BYTE_FF;
          end
        end else if (a < ADDR_PAGE0_END) begin
          if (flags.swapped) begin
            dec.res.target = TGT_LOCAL;
            dec.rd_sel     = RD_MAIN;
            dec.main_addr  = MAIN_AW'(a + ADDR_SWAP_BASE);
          end else begin
            dec.res.target        = TGT_IPL;
            dec.res.target_offset = a[11:0];
          end
        end else if (in_hi_rom) begin
          dec.res.target        = TGT_IPL;
          dec.res.target_offset = a[11:0];
        end else if (a < ADDR_VRAM) begin
          dec.res.target = TGT_LOCAL;
          dec.rd_sel     = RD_MAIN;
        end else if (a < ADDR_IO_LO) begin
          dec.res.target = TGT_LOCAL;
          dec.rd_sel     = RD_VIDEO;
        end else if (variant) begin
          dec.res.target        = TGT_EXT;
          dec.res.target_offset = ext_off[11:0];
          dec.res.result_byte   = {7'd0, ext_off[12]};
        end else begin
          dec.res.target      = TGT_LOCAL;
          dec.res.result_byte = BYTE_FF;
        end
      end
      OP_WRITE: begin
        if (in_io) begin
          if (a <= ADDR_PIO_HI) begin
            dec.res.target        = TGT_PIO;
            dec.res.target_offset = {10'd0, a[1:0]};
            dec.res.result_byte   = item.write_byte;
          end else if (a <= ADDR_TIMER_HI) begin
            dec.res.target        = TGT_TIMER;
            dec.res.target_offset = {10'd0, a[1:0]};
            dec.res.result_byte   = item.write_byte;
          end else if (a == ADDR_STATUS) begin
            dec.res.target      = TGT_GATE0;
            dec.res.result_byte = {7'd0, item.write_byte[0]};
          end else if (variant) begin
            if (a == ADDR_SWAP_ON) begin
              dec.swap_set = 1'b1;
            end else if (a == ADDR_SWAP_OFF) begin
              dec.swap_clr = 1'b1;
            end else if (a == ADDR_REV_OFF) begin
              dec.res.target = TGT_REVERSE;
            end else if (a == ADDR_REV_ON) begin
              dec.res.target      = TGT_REVERSE;
              dec.res.result_byte = 8'd1;
            end
          end
        end else if (a < ADDR_PAGE0_END) begin
          if (flags.swapped) begin
            dec.main_we   = 1'b1;
            dec.main_addr = MAIN_AW'(a + ADDR_SWAP_BASE);
          end
        end else if (in_hi_rom) begin
          dec.main_we = 1'b0;
        end else if (a < ADDR_VRAM) begin
          dec.main_we = 1'b1;
        end else if (a < ADDR_IO_LO) begin
          dec.video_we = 1'b1;
        end
      end
      OP_TEMPO: begin
        dec.tempo_tgl = 1'b1;
      end
      OP_BLINK: begin
        dec.blink_tgl         = 1'b1;
        dec.res.target        = TGT_PORTC;
        dec.res.target_offset = PORTC_BLINK;
        dec.res.result_byte   = {7'd0, ~flags.blink};
      end
      OP_LINE: begin
        if (item.line_number == LINE_VBLANK_ON) begin
          dec.res.target        = TGT_PORTC;
          dec.res.target_offset = PORTC_VBLANK;
          dec.res.result_byte   = 8'd1;
        end else if (item.line_number == LINE_VBLANK_OFF) begin
          dec.res.target        = TGT_PORTC;
          dec.res.target_offset = PORTC_VBLANK;
        end
        dec.hblank_set = variant;
      end
      OP_HBEND: begin
        dec.hblank_clr = variant;
      end
      default: begin
        dec.tempo_tgl = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/memory_map_bank_swap_decoder.sv @@
// Path: transfer -> access stage (s1) -> output register; a stall can hold either stage.
// Throughput: one item per cycle when not stalled; RAM reads and writes at the transfer edge.
// Reset: synchronous; afterwards a clearing pass zeroes main and video RAM,
// one entry per cycle, with in_ready low; cfg writes are taken throughout.
// ----------------------------------------------------------------------------
// Memory map bank swap decoder
// Bus and timing event decoder with local main RAM, video RAM and page swap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "memory_map_bank_swap_decoder_assert.svh"

module memory_map_bank_swap_decoder
  import mmbsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  logic               variant_r;
  flags_t             flags_r;
  logic               clr_done_r;
  logic [MAIN_AW-1:0] clr_cnt_r;
  logic               s1_v_r;
  out_item_t          s1_res_r;
  rd_sel_t            s1_sel_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          res_nxt;
  dec_t               dec;
  logic               accept;
  logic               out_free;
  logic               main_en;
  logic               main_we;
  logic [MAIN_AW-1:0] main_addr;
  logic [7:0]         main_wdata;
  logic [7:0]         main_rdata;
  logic               video_en;
  logic               video_we;
  logic [VIDEO_AW-1:0] video_addr;
  logic [7:0]         video_wdata;
  logic [7:0]         video_rdata;

  mmbsd_decode u_decode (
    .item    (in_data),
    .variant (variant_r),
    .flags   (flags_r),
    .dec     (dec)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = clr_done_r && (!s1_v_r || out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (!clr_done_r) begin
      main_en     = 1'b1;
      main_we     = 1'b1;
      main_addr   = clr_cnt_r;
      main_wdata  = 8'd0;
      video_en    = 1'b1;
      video_we    = 1'b1;
      video_addr  = clr_cnt_r[VIDEO_AW-1:0];
      video_wdata = 8'd0;
    end else begin
      main_en     = accept && (dec.main_we || (dec.rd_sel == RD_MAIN));
      main_we     = dec.main_we;
      main_addr   = dec.main_addr;
      main_wdata  = in_data.write_byte;
      video_en    = accept && (dec.video_we || (dec.rd_sel == RD_VIDEO));
      video_we    = dec.video_we;
      video_addr  = dec.video_addr;
      video_wdata = in_data.write_byte;
    end
  end

  mmbsd_ram #(.DEPTH(MAIN_DEPTH), .WIDTH(8)) u_main_ram (
    .clk   (clk),
    .en    (main_en),
    .we    (main_we),
    .addr  (main_addr),
    .wdata (main_wdata),
    .rdata (main_rdata)
  );

  mmbsd_ram #(.DEPTH(VIDEO_DEPTH), .WIDTH(8)) u_video_ram (
    .clk   (clk),
    .en    (video_en),
    .we    (video_we),
    .addr  (video_addr),
    .wdata (video_wdata),
    .rdata (video_rdata)
  );

  always_comb begin
    res_nxt = s1_res_r;
    case (s1_sel_r)
      RD_MAIN:  res_nxt.result_byte = main_rdata;
      RD_VIDEO: res_nxt.result_byte = video_rdata;
      default:  res_nxt.result_byte = s1_res_r.result_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r   <= 1'b0;
      flags_r     <= '0;
      clr_done_r  <= 1'b0;
      clr_cnt_r   <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        variant_r <= cfg_wdata;
      end
      if (!clr_done_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == MAIN_AW'(MAIN_DEPTH - 1)) begin
          clr_done_r <= 1'b1;
        end
      end
      if (accept) begin
        if (dec.swap_set) begin
          flags_r.swapped <= 1'b1;
        end else if (dec.swap_clr) begin
          flags_r.swapped <= 1'b0;
        end
        if (dec.tempo_tgl) begin
          flags_r.tempo <= ~flags_r.tempo;
        end
        if (dec.blink_tgl) begin
          flags_r.blink <= ~flags_r.blink;
        end
        if (dec.hblank_set) begin
          flags_r.hblank <= 1'b1;
        end else if (dec.hblank_clr) begin
          flags_r.hblank <= 1'b0;
        end
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (out_free) begin
        s1_v_r <= 1'b0;
      end
      if (s1_v_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= dec.res;
      s1_sel_r <= dec.rd_sel;
    end
    if (s1_v_r && out_free) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MMBSD_ASSERT_IMP(a_no_accept_clearing, clk, rst_n, accept, clr_done_r, "transfer while clearing")
  `MMBSD_ASSERT_NXT(a_accept_loads_s1, clk, rst_n, accept, s1_v_r, "transfer not staged")
  `MMBSD_ASSERT_NXT(a_s1_holds_on_stall, clk, rst_n, s1_v_r && out_valid && !out_ready,
                    s1_v_r && $stable(s1_res_r), "access stage lost its transfer")

endmodule

`default_nettype wire
